// ===== rtl/core/fbm_value_noise_2d_unit_assert.svh =====
// assertion macros for the fbm value noise unit
`ifndef FBM_VALUE_NOISE_2D_UNIT_ASSERT_SVH
`define FBM_VALUE_NOISE_2D_UNIT_ASSERT_SVH

// same-cycle implication
`define FVN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FVN_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/fbmvn_pkg.sv =====
// shared constants and types for the fbm value noise unit
`default_nettype none

package fbmvn_pkg;

  localparam int COORD_W    = 32;
  localparam int FRAC_W     = 16;
  localparam int AMP_W      = 17;
  localparam int FADE_W     = 17;
  localparam int MASK_W     = 31;
  localparam int WPROD_W    = 52;
  localparam int SUM_W      = 52;
  localparam int WEIGHT_W   = 20;
  localparam int QUO_W      = 18;
  localparam int OUT_W      = 18;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int OCT_W      = 4;
  localparam int LANE_LAT   = 9;

  localparam logic [31:0] HASH_MUL_Y = 32'd57;
  localparam logic [31:0] HASH_C1    = 32'd15731;
  localparam logic [31:0] HASH_C2    = 32'd789221;
  localparam logic [31:0] HASH_C3    = 32'd1376312589;

  localparam logic [AMP_W-1:0] AMP_ONE = 17'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OCTAVE_COUNT = 2'd0,
    REG_PERSISTENCE  = 2'd1
  } cfg_reg_t;

endpackage

`default_nettype wire

// ===== rtl/core/fbmvn_hash.sv =====
// four-stage integer hash of one grid corner
`default_nettype none

module fbmvn_hash import fbmvn_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [31:0]       cell_x,
  input  logic [31:0]       cell_y,
  output logic [MASK_W-1:0] mask_val
);

  logic [31:0]       h0;
  logic [31:0]       h1;
  logic [31:0]       h_r;
  logic [31:0]       hh_r;
  logic [31:0]       hb_r;
  logic [31:0]       hq_r;
  logic [31:0]       hc_r;
  logic [31:0]       m_nxt;
  logic [MASK_W-1:0] m_r;

  always_comb begin
    h0    = cell_x + cell_y * HASH_MUL_Y;
    h1    = (h0 << 13) ^ h0;
    m_nxt = hc_r * hq_r + HASH_C3;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_r  <= h1;
      hh_r <= h_r * h_r;
      hb_r <= h_r;
      hq_r <= hh_r * HASH_C1 + HASH_C2;
      hc_r <= hb_r;
      m_r  <= m_nxt[MASK_W-1:0];
    end
  end

  assign mask_val = m_r;

endmodule

`default_nettype wire

// ===== rtl/core/fbmvn_octave.sv =====
// one octave lane: cell split, corner hashes, quintic fade, bilinear blend, amplitude weight
`default_nettype none

module fbmvn_octave import fbmvn_pkg::*; #(
  parameter int LANE = 0
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [COORD_W-1:0] coord_x,
  input  logic signed [COORD_W-1:0] coord_y,
  input  logic                      active,
  input  logic [AMP_W-1:0]          amp,
  output logic signed [WPROD_W-1:0] w
);

  logic [47:0]       xs;
  logic [47:0]       ys;
  logic [31:0]       cx;
  logic [31:0]       cy;
  logic [31:0]       cx1;
  logic [31:0]       cy1;
  logic [FRAC_W-1:0] t_in [2];
  logic [MASK_W-1:0] m00;
  logic [MASK_W-1:0] m01;
  logic [MASK_W-1:0] m10;
  logic [MASK_W-1:0] m11;

  // fade pipeline per axis
  logic [FRAC_W-1:0] t_r  [2];
  logic [FRAC_W-1:0] t2_r [2];
  logic [FADE_W-1:0] s_r  [2];
  logic [19:0]       q_r  [2];
  logic [19:0]       q3_r [2];
  logic [FADE_W-1:0] c_r  [2];
  logic [FADE_W-1:0] f_r  [2];
  logic [32:0]       tt   [2];
  logic [19:0]       lin  [2];
  logic [36:0]       qs   [2];
  logic [33:0]       st   [2];
  logic [37:0]       cq   [2];
  logic [FADE_W-1:0] s_nxt [2];
  logic [19:0]       q_nxt [2];
  logic [FADE_W-1:0] c_nxt [2];
  logic [FADE_W-1:0] f_nxt [2];

  // blend pipeline
  logic signed [31:0] dxb;
  logic signed [31:0] dxt;
  logic signed [49:0] pb_r;
  logic signed [49:0] pt_r;
  logic signed [31:0] c00_r;
  logic signed [31:0] c01_r;
  logic [FADE_W-1:0]  fy5_r;
  logic [FADE_W-1:0]  fy6_r;
  logic signed [49:0] rb;
  logic signed [49:0] rt;
  logic signed [33:0] bot_r;
  logic signed [33:0] top_r;
  logic signed [33:0] bot7_r;
  logic signed [34:0] dv;
  logic signed [52:0] pv_r;
  logic signed [52:0] rv;
  logic signed [34:0] v_r;
  logic signed [52:0] wp;
  logic signed [WPROD_W-1:0] w_r;

  always_comb begin
    xs      = 48'(coord_x) << LANE;
    ys      = 48'(coord_y) << LANE;
    cx      = xs[47:16];
    cy      = ys[47:16];
    cx1     = cx + 32'd1;
    cy1     = cy + 32'd1;
    t_in[0] = xs[15:0];
    t_in[1] = ys[15:0];
  end

  fbmvn_hash u_h00 (.clk(clk), .en(en), .cell_x(cx),  .cell_y(cy),  .mask_val(m00));
  fbmvn_hash u_h01 (.clk(clk), .en(en), .cell_x(cx),  .cell_y(cy1), .mask_val(m01));
  fbmvn_hash u_h10 (.clk(clk), .en(en), .cell_x(cx1), .cell_y(cy),  .mask_val(m10));
  fbmvn_hash u_h11 (.clk(clk), .en(en), .cell_x(cx1), .cell_y(cy1), .mask_val(m11));

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      tt[a]    = 33'(t_r[a]) * 33'(t_r[a]) + 33'd32768;
      s_nxt[a] = tt[a][32:16];
      lin[a]   = 20'd983040 - 20'(t_r[a]) * 20'd6;
      qs[a]    = 37'd42949672960 - 37'(t_r[a]) * 37'(lin[a]) + 37'd32768;
      q_nxt[a] = qs[a][35:16];
      st[a]    = 34'(s_r[a]) * 34'(t2_r[a]) + 34'd32768;
      c_nxt[a] = st[a][32:16];
      cq[a]    = 38'(c_r[a]) * 38'(q3_r[a]) + 38'd32768;
      f_nxt[a] = (cq[a][37:16] > 22'd65536) ? AMP_ONE : cq[a][32:16];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 2; a++) begin
        t_r[a]  <= t_in[a];
        s_r[a]  <= s_nxt[a];
        q_r[a]  <= q_nxt[a];
        t2_r[a] <= t_r[a];
        c_r[a]  <= c_nxt[a];
        q3_r[a] <= q_r[a];
        f_r[a]  <= f_nxt[a];
      end
    end
  end

  always_comb begin
    dxb = $signed({1'b0, m00}) - $signed({1'b0, m10});
    dxt = $signed({1'b0, m01}) - $signed({1'b0, m11});
    rb  = (pb_r + 50'sd32768) >>> 16;
    rt  = (pt_r + 50'sd32768) >>> 16;
    dv  = 35'(top_r) - 35'(bot_r);
    rv  = (pv_r + 53'sd32768) >>> 16;
    wp  = 53'(v_r) * 53'($signed({1'b0, amp}));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pb_r   <= 50'(dxb) * 50'($signed({1'b0, f_r[0]}));
      pt_r   <= 50'(dxt) * 50'($signed({1'b0, f_r[0]}));
      c00_r  <= 32'sd1073741824 - $signed({1'b0, m00});
      c01_r  <= 32'sd1073741824 - $signed({1'b0, m01});
      fy5_r  <= f_r[1];
      bot_r  <= 34'(c00_r) + $signed(rb[33:0]);
      top_r  <= 34'(c01_r) + $signed(rt[33:0]);
      fy6_r  <= fy5_r;
      pv_r   <= 53'(dv) * 53'($signed({1'b0, fy6_r}));
      bot7_r <= bot_r;
      v_r    <= 35'(bot7_r) + $signed(rv[34:0]);
      w_r    <= active ? wp[WPROD_W-1:0] : '0;
    end
  end

  assign w = w_r;

endmodule

`default_nettype wire

// ===== rtl/core/fbmvn_div.sv =====
// pipelined restoring divider, rounding, sign and saturation of the noise sum
`default_nettype none

module fbmvn_div import fbmvn_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_vld,
  input  logic signed [SUM_W-1:0] in_sum,
  input  logic [WEIGHT_W-1:0]     weight,
  input  logic                    zero,
  output logic                    out_vld,
  output logic signed [OUT_W-1:0] out_val
);

  localparam int REM_W = SUM_W + 1;

  logic [REM_W-1:0] rem_r [QUO_W+1];
  logic [QUO_W-1:0] quo_r [QUO_W+1];
  logic             neg_r [QUO_W+1];
  logic [QUO_W:0]   vld_r;
  logic [REM_W-1:0] rem_nxt [QUO_W+1];
  logic [QUO_W-1:0] quo_nxt [QUO_W+1];
  logic [REM_W-1:0] dsh     [QUO_W+1];
  logic [REM_W-1:0] mag_sum;
  logic [QUO_W-1:0] sat;
  logic signed [OUT_W-1:0] val_nxt;
  logic             out_vld_r;
  logic signed [OUT_W-1:0] out_val_r;

  always_comb begin
    mag_sum    = in_sum[SUM_W-1] ? REM_W'(-in_sum) : REM_W'(in_sum);
    rem_nxt[0] = mag_sum + (REM_W'(weight) << 13);
    quo_nxt[0] = '0;
    dsh[0]     = '0;
    for (int j = 1; j <= QUO_W; j++) begin
      dsh[j]     = (REM_W'(weight) << 14) << (QUO_W - j);
      rem_nxt[j] = rem_r[j-1];
      quo_nxt[j] = quo_r[j-1];
      if (rem_r[j-1] >= dsh[j]) begin
        rem_nxt[j] = rem_r[j-1] - dsh[j];
        quo_nxt[j][QUO_W-j] = 1'b1;
      end
    end
    sat     = (quo_r[QUO_W] > QUO_W'(65536)) ? QUO_W'(65536) : quo_r[QUO_W];
    val_nxt = zero ? '0 : (neg_r[QUO_W] ? -$signed(sat) : $signed(sat));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= rem_nxt[0];
      quo_r[0] <= quo_nxt[0];
      neg_r[0] <= in_sum[SUM_W-1];
      for (int j = 1; j <= QUO_W; j++) begin
        rem_r[j] <= rem_nxt[j];
        quo_r[j] <= quo_nxt[j];
        neg_r[j] <= neg_r[j-1];
      end
      out_val_r <= val_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld_r     <= {vld_r[QUO_W-1:0], in_vld};
      out_vld_r <= vld_r[QUO_W];
    end
  end

  assign out_vld = out_vld_r;
  assign out_val = out_val_r;

endmodule

`default_nettype wire

// ===== rtl/core/fbm_value_noise_2d_unit.sv =====
// top level of the fbm value noise unit
//
// input channel: in_valid/in_stall with in_coord_x, in_coord_y (signed Q16.16)
// output channel: out_valid/out_stall with out_noise_value (signed Q1.16)
// config port: cfg_we writes cfg_data to register cfg_index
//   (octave count, persistence); other indexes change no register
// one point enters per clock while in_stall is low; every octave has
//   its own lane, so the rate does not depend on the octave count
// the result passes through the input register, 9 lane stages,
//   2 adder stages, 19 divider stages and the output register
//   before it shows on the out ports
// after reset and after any config write, in_stall stays high while
//   the settle counter runs down and the amplitude chain and weight settle
// reset clears all valid bits and loads count 4, persistence 0.5
// when out_valid is held by out_stall the whole pipeline freezes and
//   in_stall is raised; nothing is dropped or repeated
`default_nettype none

module fbm_value_noise_2d_unit import fbmvn_pkg::*; #(
  parameter int MAX_OCTAVES = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] in_coord_x,
  input  logic signed [COORD_W-1:0] in_coord_y,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [OUT_W-1:0]   out_noise_value,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  localparam int PRE_LAT  = 1 + LANE_LAT + 2;
  localparam int NPAIR    = (MAX_OCTAVES + 1) / 2;
  localparam int SETTLE_W = $clog2(MAX_OCTAVES + 2);

  logic [OCT_W-1:0]          oct_cnt_r;
  logic [AMP_W-1:0]          pers_r;
  logic [SETTLE_W-1:0]       settle_r;
  logic [AMP_W-1:0]          amp_r [MAX_OCTAVES];
  logic [WEIGHT_W-1:0]       weight_r;
  logic [WEIGHT_W-1:0]       weight_nxt;
  logic [OCT_W-1:0]          cnt_sat;
  logic [AMP_W-1:0]          pers_sat;
  logic [33:0]               amp_prod [MAX_OCTAVES];
  logic [MAX_OCTAVES-1:0]    lane_on;
  logic                      settle_busy;
  logic                      en;
  logic [PRE_LAT-1:0]        vld_r;
  logic signed [COORD_W-1:0] x_r;
  logic signed [COORD_W-1:0] y_r;
  logic signed [WPROD_W-1:0] lane_w [MAX_OCTAVES];
  logic signed [SUM_W-1:0]   pair_r [NPAIR];
  logic signed [SUM_W-1:0]   pair_nxt [NPAIR];
  logic signed [SUM_W-1:0]   sum_r;
  logic signed [SUM_W-1:0]   sum_nxt;

  assign en          = !(out_valid && out_stall);
  assign settle_busy = (settle_r != '0);
  assign in_stall    = !en || settle_busy;

  always_comb begin
    cnt_sat    = (oct_cnt_r > OCT_W'(MAX_OCTAVES)) ? OCT_W'(MAX_OCTAVES) : oct_cnt_r;
    pers_sat   = (pers_r > AMP_ONE) ? AMP_ONE : pers_r;
    weight_nxt = '0;
    for (int k = 0; k < MAX_OCTAVES; k++) begin
      lane_on[k]  = (OCT_W'(k) < cnt_sat);
      amp_prod[k] = 34'(amp_r[k]) * 34'(pers_sat) + 34'd32768;
      if (lane_on[k]) begin
        weight_nxt = weight_nxt + WEIGHT_W'(amp_r[k]);
      end
    end
  end

  // config registers and settle counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oct_cnt_r <= OCT_W'(4);
      pers_r    <= AMP_W'(32768);
      settle_r  <= SETTLE_W'(MAX_OCTAVES + 1);
    end else begin
      if (cfg_we) begin
        settle_r <= SETTLE_W'(MAX_OCTAVES + 1);
        case (cfg_reg_t'(cfg_index))
          REG_OCTAVE_COUNT: begin
            oct_cnt_r <= cfg_data[OCT_W-1:0];
          end
          REG_PERSISTENCE: begin
            pers_r <= cfg_data;
          end
          default: begin
          end
        endcase
      end else if (settle_busy) begin
        settle_r <= settle_r - SETTLE_W'(1);
      end
    end
  end

  // amplitude chain, one multiply per octave step
  always_ff @(posedge clk) begin
    amp_r[0] <= AMP_ONE;
    for (int k = 1; k < MAX_OCTAVES; k++) begin
      amp_r[k] <= amp_prod[k-1][32:16];
    end
    weight_r <= weight_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PRE_LAT-2:0], in_valid && !settle_busy};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= in_coord_x;
      y_r <= in_coord_y;
    end
  end

  for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_lane
    fbmvn_octave #(.LANE(k)) u_oct (
      .clk     (clk),
      .en      (en),
      .coord_x (x_r),
      .coord_y (y_r),
      .active  (lane_on[k]),
      .amp     (amp_r[k]),
      .w       (lane_w[k])
    );
  end

  for (genvar p = 0; p < NPAIR; p++) begin : g_pair
    if (2 * p + 1 < MAX_OCTAVES) begin : g_two
      assign pair_nxt[p] = lane_w[2*p] + lane_w[2*p+1];
    end else begin : g_one
      assign pair_nxt[p] = lane_w[2*p];
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int p = 0; p < NPAIR; p++) begin
      sum_nxt = sum_nxt + pair_r[p];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int p = 0; p < NPAIR; p++) begin
        pair_r[p] <= pair_nxt[p];
      end
      sum_r <= sum_nxt;
    end
  end

  fbmvn_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (vld_r[PRE_LAT-1]),
    .in_sum  (sum_r),
    .weight  (weight_r),
    .zero    (cnt_sat == '0),
    .out_vld (out_valid),
    .out_val (out_noise_value)
  );

endmodule

`default_nettype wire

// ===== rtl/core/fbmvn_checker.sv =====
// port-level checker for the fbm value noise unit and its bind
`default_nettype none
`include "fbm_value_noise_2d_unit_assert.svh"

module fbmvn_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [17:0] out_noise_value
);

  `FVN_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_noise_value), "result changed while stalled")
  `FVN_ASSERT_IMP(a_out_range, out_valid, (out_noise_value <= 18'sd65536) && (out_noise_value >= -18'sd65536), "noise out of range")
  `FVN_ASSERT_IMP(a_backpressure, out_valid && out_stall, in_stall, "input open while output stalled")

endmodule

bind fbm_value_noise_2d_unit fbmvn_checker u_checker (.*);

`default_nettype wire
